// File: src/ntg_pkg.sv
package ntg_pkg;

    localparam int PRESCALE_DEFAULT = 128;
    localparam int NOTE_COUNT       = 12;
    localparam int ACTION_W         = 2;
    localparam int NOTE_W           = 4;
    localparam int OCTAVE_W         = 4;
    localparam int COMPARE_W        = 8;
    localparam int IN_TDATA_W       = 16;
    localparam int OUT_TDATA_W      = 16;

    localparam logic [COMPARE_W-1:0] COMPARE_RESET = 8'd141;

    localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NOTE_ON  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 2'd2;

    typedef struct packed {
        logic signed [OCTAVE_W-1:0] octave_shift;
        logic [NOTE_W-1:0]          note_index;
        logic [ACTION_W-1:0]        action;
    } item_t;

    typedef struct packed {
        logic [COMPARE_W-1:0] period_compare;
        logic                 tone_active;
        logic                 audio_level;
    } result_t;

    // timer period for one semitone in the base octave
    function automatic logic [COMPARE_W-1:0] period_entry(input logic [NOTE_W-1:0] note);
        logic [COMPARE_W-1:0] entry;
        case (note)
            4'd0:    entry = 8'd238;
            4'd1:    entry = 8'd224;
            4'd2:    entry = 8'd212;
            4'd3:    entry = 8'd200;
            4'd4:    entry = 8'd189;
            4'd5:    entry = 8'd178;
            4'd6:    entry = 8'd168;
            4'd7:    entry = 8'd158;
            4'd8:    entry = 8'd149;
            4'd9:    entry = 8'd141;
            4'd10:   entry = 8'd133;
            4'd11:   entry = 8'd126;
            default: entry = 8'd0;
        endcase
        return entry;
    endfunction

endpackage

// File: src/ntg_pitch.sv
module ntg_pitch (
    input  logic [ntg_pkg::NOTE_W-1:0]          note_index,
    input  logic signed [ntg_pkg::OCTAVE_W-1:0] octave_shift,
    output logic                                note_valid,
    output logic [ntg_pkg::COMPARE_W-1:0]       note_compare
);

    localparam int HALF_W = ntg_pkg::COMPARE_W + 1;
    localparam int WIDE_W = 2 * ntg_pkg::COMPARE_W + 1;
    localparam logic [HALF_W-1:0] PERIOD_MAX = HALF_W'(1) << ntg_pkg::COMPARE_W;

    logic [HALF_W-1:0]            half_period;
    logic [HALF_W-1:0]            up_period;
    logic [HALF_W-1:0]            down_period;
    logic [WIDE_W-1:0]            down_wide;
    logic [ntg_pkg::OCTAVE_W-1:0] down_amount;
    logic [HALF_W-1:0]            period_sel;

    assign note_valid  = ({1'b0, note_index} < 5'(ntg_pkg::NOTE_COUNT));
    assign half_period = {1'b0, ntg_pkg::period_entry(note_index)} + HALF_W'(1);
    assign down_amount = ~octave_shift + ntg_pkg::OCTAVE_W'(1);

    always_comb begin
        up_period = half_period >> octave_shift[ntg_pkg::OCTAVE_W-2:0];
        if (up_period == '0) begin
            up_period = HALF_W'(1);
        end
        down_wide = WIDE_W'(half_period) << down_amount;
        if (down_wide > WIDE_W'(PERIOD_MAX)) begin
            down_period = PERIOD_MAX;
        end else begin
            down_period = down_wide[HALF_W-1:0];
        end
        if (octave_shift[ntg_pkg::OCTAVE_W-1]) begin
            period_sel = down_period;
        end else begin
            period_sel = up_period;
        end
    end

    assign note_compare = ntg_pkg::COMPARE_W'(period_sel - HALF_W'(1));

endmodule

// File: src/ntg_timer.sv
module ntg_timer #(
    parameter int PRESCALE = ntg_pkg::PRESCALE_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step_en,
    input  ntg_pkg::item_t                 item,
    input  logic                           note_valid,
    input  logic [ntg_pkg::COMPARE_W-1:0]  note_compare,
    output ntg_pkg::result_t               result_next
);

    localparam int PRE_W = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
    localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(PRESCALE - 1);

    logic [PRE_W-1:0]              prescale_count_reg, prescale_count_next;
    logic [ntg_pkg::COMPARE_W-1:0] timer_count_reg, timer_count_next;
    logic [ntg_pkg::COMPARE_W-1:0] compare_value_reg, compare_value_next;
    logic                          output_enabled_reg, output_enabled_next;
    logic                          toggle_level_reg, toggle_level_next;

    always_comb begin
        prescale_count_next = prescale_count_reg;
        timer_count_next    = timer_count_reg;
        compare_value_next  = compare_value_reg;
        output_enabled_next = output_enabled_reg;
        toggle_level_next   = toggle_level_reg;
        case (item.action)
            ntg_pkg::ACT_TICK: begin
                if (prescale_count_reg == PRE_LAST) begin
                    prescale_count_next = '0;
                    if (timer_count_reg == compare_value_reg) begin
                        timer_count_next = '0;
                        if (output_enabled_reg) begin
                            toggle_level_next = ~toggle_level_reg;
                        end
                    end else begin
                        timer_count_next = timer_count_reg + ntg_pkg::COMPARE_W'(1);
                    end
                end else begin
                    prescale_count_next = prescale_count_reg + PRE_W'(1);
                end
            end
            ntg_pkg::ACT_NOTE_ON: begin
                if (note_valid) begin
                    compare_value_next  = note_compare;
                    output_enabled_next = 1'b1;
                end else begin
                    output_enabled_next = 1'b0;
                end
            end
            ntg_pkg::ACT_NOTE_OFF: begin
                output_enabled_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign result_next.audio_level    = output_enabled_next & toggle_level_next;
    assign result_next.tone_active    = output_enabled_next;
    assign result_next.period_compare = compare_value_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_count_reg <= '0;
            timer_count_reg    <= '0;
            compare_value_reg  <= ntg_pkg::COMPARE_RESET;
            output_enabled_reg <= 1'b0;
            toggle_level_reg   <= 1'b0;
        end else if (step_en) begin
            prescale_count_reg <= prescale_count_next;
            timer_count_reg    <= timer_count_next;
            compare_value_reg  <= compare_value_next;
            output_enabled_reg <= output_enabled_next;
            toggle_level_reg   <= toggle_level_next;
        end
    end

endmodule

// File: src/note_tone_generator.sv
// square-wave tone generator on a pair of streams
// s_ side: one request per tick, note on or note off; every request gives
//   exactly one result on the m_ side, in order
// m_ side: pin level, tone active flag and current compare value, taken
//   after the request has updated the timer state
// path: a request accepted into the request register has its result taken into
//   the result register, shown on m_tdata, once that register is empty or m_tready is high
// throughput: one request per cycle while m_tready is high; the request register,
//   the timer update and the result register run concurrently
// stall: while m_tready is low the result register holds; one more request
//   waits in the request register, then s_tready drops until m_tready returns
// reset: aresetn low clears both registers, the prescaler and timer, sets the
//   compare value to 141 and silences the output; the block takes requests in
//   the first cycle after reset
module note_tone_generator #(
    parameter int PRESCALE = ntg_pkg::PRESCALE_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action [1:0], note_index [5:2], octave_shift [9:6]
    input  logic [ntg_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // audio_level [0], tone_active [1], period_compare [9:2]
    output logic [ntg_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int ITEM_W   = $bits(ntg_pkg::item_t);
    localparam int RESULT_W = $bits(ntg_pkg::result_t);

    logic                          in_valid_reg;
    ntg_pkg::item_t                item_reg;
    logic                          out_valid_reg;
    ntg_pkg::result_t              result_reg;
    ntg_pkg::result_t              result_next;
    logic                          advance;
    logic                          note_valid;
    logic [ntg_pkg::COMPARE_W-1:0] note_compare;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ntg_pkg::OUT_TDATA_W - RESULT_W){1'b0}}, result_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= ntg_pkg::item_t'(s_tdata[ITEM_W-1:0]);
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    ntg_pitch u_pitch (
        .note_index   (item_reg.note_index),
        .octave_shift (item_reg.octave_shift),
        .note_valid   (note_valid),
        .note_compare (note_compare)
    );

    ntg_timer #(
        .PRESCALE (PRESCALE)
    ) u_timer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .item         (item_reg),
        .note_valid   (note_valid),
        .note_compare (note_compare),
        .result_next  (result_next)
    );

endmodule

// File: test/note_tone_generator_test.sv
module note_tone_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKS_PER_STEP = ntg_pkg::PRESCALE_DEFAULT;
    localparam logic [ntg_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD = 300;
    localparam logic [ntg_pkg::COMPARE_W-1:0] BASE_PERIOD [ntg_pkg::NOTE_COUNT] = '{
        8'd238, 8'd224, 8'd212, 8'd200, 8'd189, 8'd178,
        8'd168, 8'd158, 8'd149, 8'd141, 8'd133, 8'd126
    };

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ntg_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ntg_pkg::OUT_TDATA_W-1:0] m_tdata;

    note_tone_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    ntg_pkg::item_t   pending_requests[$];
    ntg_pkg::result_t expected_tones[$];
    logic    req_taken = 1'b0;
    int      src_idle_pct = 0;
    int      sink_stall_pct = 0;
    int      hold_cycles = 0;
    int      stuck_cycles = 0;
    int      mismatch_count = 0;

    // predicted timer state
    int                            prescale_pos;
    logic [7:0]                    timer_pos;
    logic [ntg_pkg::COMPARE_W-1:0] half_period;
    logic                          tone_on;
    logic                          pin_latch;

    int      tick_count = 0;
    int      note_on_count = 0;
    int      note_off_count = 0;
    int      unused_count = 0;
    int      pin_edges = 0;
    logic    last_pin = 1'b0;

    function automatic logic [ntg_pkg::COMPARE_W-1:0] scaled_compare(
            logic [ntg_pkg::NOTE_W-1:0] note, logic signed [ntg_pkg::OCTAVE_W-1:0] oct);
        int span;
        int octs;
        span = int'(BASE_PERIOD[note]) + 1;
        octs = oct;
        if (octs > 0) begin
            span = span >> octs;
            if (span < 1) span = 1;
        end else if (octs < 0) begin
            span = span << (-octs);
            if (span > 256) span = 256;
        end
        return ntg_pkg::COMPARE_W'(span - 1);
    endfunction

    function automatic ntg_pkg::result_t tone_after(ntg_pkg::item_t req);
        ntg_pkg::result_t r;
        case (req.action)
            ntg_pkg::ACT_TICK: begin
                tick_count++;
                if (prescale_pos + 1 >= TICKS_PER_STEP) begin
                    prescale_pos = 0;
                    if (timer_pos == half_period) begin
                        timer_pos = '0;
                        if (tone_on) pin_latch = ~pin_latch;
                    end else begin
                        timer_pos = timer_pos + 8'd1;
                    end
                end else begin
                    prescale_pos++;
                end
            end
            ntg_pkg::ACT_NOTE_ON: begin
                note_on_count++;
                if (req.note_index < ntg_pkg::NOTE_COUNT) begin
                    half_period = scaled_compare(req.note_index, req.octave_shift);
                    tone_on = 1'b1;
                end else begin
                    tone_on = 1'b0;
                end
            end
            ntg_pkg::ACT_NOTE_OFF: begin
                note_off_count++;
                tone_on = 1'b0;
            end
            default: unused_count++;
        endcase
        r.audio_level = tone_on & pin_latch;
        r.tone_active = tone_on;
        r.period_compare = half_period;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tdata <= ntg_pkg::IN_TDATA_W'(pending_requests.pop_front());
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // monitor and predictor
    always @(posedge aclk) begin
        ntg_pkg::result_t got;
        ntg_pkg::result_t want;
        req_taken <= s_tvalid && s_tready;
        if (!aresetn) begin
            prescale_pos = 0;
            timer_pos = '0;
            half_period = ntg_pkg::COMPARE_RESET;
            tone_on = 1'b0;
            pin_latch = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = ntg_pkg::result_t'(m_tdata[$bits(ntg_pkg::result_t)-1:0]);
                if (got.audio_level != last_pin) pin_edges++;
                last_pin = got.audio_level;
                if (expected_tones.size() == 0) begin
                    report_mismatch("result with no request outstanding", 1, 0);
                end else begin
                    want = expected_tones.pop_front();
                    if (got.audio_level != want.audio_level)
                        report_mismatch("audio_level", got.audio_level, want.audio_level);
                    if (got.tone_active != want.tone_active)
                        report_mismatch("tone_active", got.tone_active, want.tone_active);
                    if (got.period_compare != want.period_compare)
                        report_mismatch("period_compare", got.period_compare,
                                        want.period_compare);
                end
            end
            if (s_tvalid && s_tready)
                expected_tones.push_back(tone_after(
                    ntg_pkg::item_t'(s_tdata[$bits(ntg_pkg::item_t)-1:0])));
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn && (pending_requests.size() > 0 || s_tvalid || expected_tones.size() > 0)
                && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles + 1 >= STALL_LIMIT) begin
                $display("stalled for %0d cycles at %0t", STALL_LIMIT, $realtime);
                $display("note_tone_generator regression: fail");
                $finish;
            end
        end else begin
            stuck_cycles <= 0;
        end
    end

    task automatic queue_request(logic [ntg_pkg::ACTION_W-1:0] act,
                                 logic [ntg_pkg::NOTE_W-1:0] note,
                                 logic [ntg_pkg::OCTAVE_W-1:0] oct);
        ntg_pkg::item_t req;
        req.action = act;
        req.note_index = note;
        req.octave_shift = oct;
        pending_requests.push_back(req);
    endtask

    // ticks carry random note and octave fields, which must be ignored
    task automatic queue_ticks(int n);
        repeat (n) queue_request(ntg_pkg::ACT_TICK, 4'($urandom), 4'($urandom));
    endtask

    task automatic queue_phrase();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            if ($urandom_range(9) == 0)
                queue_request(ntg_pkg::ACT_NOTE_ON, 4'($urandom_range(15, 12)),
                              4'($urandom));
            else if ($urandom_range(1) == 0)
                queue_request(ntg_pkg::ACT_NOTE_ON, 4'($urandom_range(11)),
                              4'($urandom_range(7, 3)));
            else
                queue_request(ntg_pkg::ACT_NOTE_ON, 4'($urandom_range(11)), 4'($urandom));
        end else if (pick < 70) begin
            queue_request(ntg_pkg::ACT_NOTE_OFF, 4'($urandom), 4'($urandom));
        end else if (pick < 78) begin
            queue_request(ACT_UNUSED, 4'($urandom), 4'($urandom));
        end
        if ($urandom_range(4) == 0)
            queue_ticks($urandom_range(60, 20));
        else
            queue_ticks($urandom_range(12));
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_tones.size() != 0);
    endtask

    task automatic run_random_phase(int src_pct, int sink_pct, int phrases, bit long_hold);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        repeat (phrases) queue_phrase();
        if (long_hold) begin
            @(posedge aclk);
            hold_cycles = LONG_HOLD;
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: field extremes, every action, silencing and octave limits
        queue_request(ntg_pkg::ACT_TICK, 4'd15, 4'd8);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd0, 4'd0);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd11, 4'd7);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd0, 4'd8);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd11, 4'd8);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd5, 4'd15);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd9, 4'd1);
        queue_request(ACT_UNUSED, 4'd15, 4'd15);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd12, 4'd0);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd3, 4'd2);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd15, 4'd7);
        queue_request(ntg_pkg::ACT_NOTE_OFF, 4'd15, 4'd7);
        queue_request(ACT_UNUSED, 4'd0, 4'd0);
        queue_request(ntg_pkg::ACT_NOTE_OFF, 4'd0, 4'd8);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd7, 4'd4);
        queue_request(ntg_pkg::ACT_TICK, 4'd0, 4'd7);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd2, 4'd3);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd11, 4'd7);
        wait_drained();

        // fast toggling, then silence while matches go on, then resume
        queue_ticks(2 * TICKS_PER_STEP);
        queue_request(ntg_pkg::ACT_NOTE_OFF, 4'd0, 4'd0);
        queue_ticks(TICKS_PER_STEP);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd11, 4'd7);
        queue_ticks(TICKS_PER_STEP);
        // slowest tone, let the counter climb, then drop the compare below it
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd0, 4'd8);
        queue_ticks(2 * TICKS_PER_STEP);
        queue_request(ntg_pkg::ACT_NOTE_ON, 4'd11, 4'd7);
        queue_ticks(TICKS_PER_STEP);
        wait_drained();

        run_random_phase(0, 0, 10, 1'b1);
        run_random_phase(67, 0, 10, 1'b0);
        run_random_phase(0, 67, 10, 1'b1);
        run_random_phase(19, 19, 10, 1'b0);

        src_idle_pct = 0;
        sink_stall_pct = 0;
        repeat (8) @(posedge aclk);

        $display("covered %0d ticks, %0d note on, %0d note off, %0d unused-code requests",
                 tick_count, note_on_count, note_off_count, unused_count);
        $display("pin level changed %0d times across idle, stall and back-pressure phases",
                 pin_edges);
        if (mismatch_count == 0) begin
            $display("note_tone_generator regression: pass");
        end else begin
            $display("note_tone_generator regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
src/ntg_pkg.sv
src/ntg_pitch.sv
src/ntg_timer.sv
src/note_tone_generator.sv
test/note_tone_generator_test.sv
